### design/servo_command_packet_framer_unit_assert.svh
// ---------------------------------------------------------------------------
// Servo command packet framer assertion macros
// Shared concurrent assertion forms for the framer checker.
// ---------------------------------------------------------------------------
`ifndef SERVO_COMMAND_PACKET_FRAMER_UNIT_ASSERT_SVH
`define SERVO_COMMAND_PACKET_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCPF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/scpf_pkg.sv
// ---------------------------------------------------------------------------
// Servo command packet framer package
// Opcodes, item and packet types and framing constants.
// ---------------------------------------------------------------------------
package scpf_pkg;

  // Command kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_OPERATION     = 2'd0,
    OP_SET           = 2'd1,
    OP_SYNC_HEADER   = 2'd2,
    OP_SYNC_POSITION = 2'd3
  } opcode_e;

  localparam int unsigned PKT_BYTES = 6;
  localparam int unsigned LEN_W     = 3;

  localparam logic [7:0] FRAME_HEADER  = 8'hFF;
  localparam logic [4:0] MODE_LOW_BITS = 5'h1F;
  localparam logic [4:0] MAX_LAST_ID   = 5'd30;

  // One input item
  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;
    logic [7:0] data_d;
    logic [4:0] last_servo;
    logic [2:0] speed;
    logic [7:0] position;
  } item_t;

  // Bytes caused by one item; byte 0 goes out first
  typedef struct packed {
    logic [PKT_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      has_check;
  } packet_t;

endpackage

### design/servo_command_packet_framer_unit.sv
// ---------------------------------------------------------------------------
// Servo command packet framer
// Frames servo bus commands into transmit bytes with header and checksum.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream takes one command per transfer: opcode on tuser, the data
//   fields packed in tdata. Master stream gives one transmit byte per
//   transfer: tlast marks the last byte caused by a command, tuser marks a
//   frame checksum byte.
//   An operation command gives 4 bytes, a set command 6, a sync header 3,
//   a sync position 1 (2 when it closes the frame, 0 when no frame is open).
//   First byte of a command is valid once it is loaded into the serializer.
//   Throughput: one byte per cycle while the receiver is ready and commands
//   are waiting. The next command waits in the input register while the
//   current packet drains, and a dropped position sends no byte.
//   Reset clears both registers and closes any sync frame.
//   When the receiver stalls, the current byte holds and the input register
//   fills, then the slave tready drops.
// ---------------------------------------------------------------------------
module servo_command_packet_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: data_a[7:0], data_b[15:8], data_c[23:16], data_d[31:24],
  //        last_servo[36:32], speed[39:37], position[47:40]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,   // last_of_run
  output logic        m_axis_tuser    // end_of_packet
);

  scpf_pkg::item_t   item;
  scpf_pkg::packet_t packet;
  logic              item_valid;
  logic              ser_free;
  logic              move;

  // Move an item to the serializer once its packet slot frees
  assign move = item_valid && ser_free;

  scpf_item_reg u_item_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (move),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  scpf_frame_builder u_frame_builder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (move),
    .item_i   (item),
    .packet_o (packet)
  );

  scpf_byte_serializer u_byte_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (move),
    .packet_i      (packet),
    .free_o        (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### design/scpf_item_reg.sv
// ---------------------------------------------------------------------------
// Servo command packet framer input register
// Captures one input transfer and holds it until the builder takes it.
// ---------------------------------------------------------------------------
module scpf_item_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [47:0]    s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  input  logic           take_i,
  output logic           valid_o,
  output scpf_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  scpf_pkg::item_t item_q;
  logic            accept;

  assign s_axis_tready = !valid_q || take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold the item until it moves on, refill on the same cycle if offered
  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unpack the payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode     <= scpf_pkg::opcode_e'(s_axis_tuser);
      item_q.data_a     <= s_axis_tdata[7:0];
      item_q.data_b     <= s_axis_tdata[15:8];
      item_q.data_c     <= s_axis_tdata[23:16];
      item_q.data_d     <= s_axis_tdata[31:24];
      item_q.last_servo <= s_axis_tdata[36:32];
      item_q.speed      <= s_axis_tdata[39:37];
      item_q.position   <= s_axis_tdata[47:40];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### design/scpf_frame_builder.sv
// ---------------------------------------------------------------------------
// Servo command packet framer frame builder
// Forms the bytes of one item and tracks the open sync frame.
// ---------------------------------------------------------------------------
module scpf_frame_builder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  scpf_pkg::item_t   item_i,
  output scpf_pkg::packet_t packet_o
);

  logic [6:0] xor_q, xor_d;
  logic [4:0] left_q, left_d;
  logic [4:0] last_id;
  logic [4:0] count;
  logic [6:0] xor_next;

  // Clamp the last id so the count fits five bits
  assign last_id  = (item_i.last_servo > scpf_pkg::MAX_LAST_ID) ?
                    scpf_pkg::MAX_LAST_ID : item_i.last_servo;
  assign count    = last_id + 5'd1;
  assign xor_next = xor_q ^ item_i.position[6:0];

  // Build the packet and the next sync state
  always_comb begin
    packet_o = '0;
    xor_d    = xor_q;
    left_d   = left_q;
    case (item_i.opcode)
      scpf_pkg::OP_OPERATION: begin
        packet_o.bytes[0]  = scpf_pkg::FRAME_HEADER;
        packet_o.bytes[1]  = item_i.data_a;
        packet_o.bytes[2]  = item_i.data_b;
        packet_o.bytes[3]  = {1'b0, item_i.data_a[6:0] ^ item_i.data_b[6:0]};
        packet_o.len       = 3'd4;
        packet_o.has_check = 1'b1;
        xor_d              = '0;
        left_d             = '0;
      end
      scpf_pkg::OP_SET: begin
        packet_o.bytes[0]  = scpf_pkg::FRAME_HEADER;
        packet_o.bytes[1]  = item_i.data_a;
        packet_o.bytes[2]  = item_i.data_b;
        packet_o.bytes[3]  = item_i.data_c;
        packet_o.bytes[4]  = item_i.data_d;
        packet_o.bytes[5]  = {1'b0, item_i.data_a[6:0] ^ item_i.data_b[6:0] ^
                                    item_i.data_c[6:0] ^ item_i.data_d[6:0]};
        packet_o.len       = 3'd6;
        packet_o.has_check = 1'b1;
        xor_d              = '0;
        left_d             = '0;
      end
      scpf_pkg::OP_SYNC_HEADER: begin
        packet_o.bytes[0] = scpf_pkg::FRAME_HEADER;
        packet_o.bytes[1] = {item_i.speed, scpf_pkg::MODE_LOW_BITS};
        packet_o.bytes[2] = {3'b000, count};
        packet_o.len      = 3'd3;
        xor_d             = '0;
        left_d            = count;
      end
      scpf_pkg::OP_SYNC_POSITION: begin
        // Drop positions outside an open frame
        if (left_q != 5'd0) begin
          packet_o.bytes[0] = item_i.position;
          left_d            = left_q - 5'd1;
          if (left_q == 5'd1) begin
            packet_o.bytes[1]  = {1'b0, xor_next};
            packet_o.len       = 3'd2;
            packet_o.has_check = 1'b1;
            xor_d              = '0;
          end else begin
            packet_o.len = 3'd1;
            xor_d        = xor_next;
          end
        end
      end
      default: begin
        packet_o = '0;
      end
    endcase
  end

  // Advance the sync state only when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q  <= '0;
      left_q <= '0;
    end else if (fire_i) begin
      xor_q  <= xor_d;
      left_q <= left_d;
    end
  end

endmodule

### design/scpf_byte_serializer.sv
// ---------------------------------------------------------------------------
// Servo command packet framer byte serializer
// Holds one built packet and sends its bytes one transfer at a time.
// ---------------------------------------------------------------------------
module scpf_byte_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  scpf_pkg::packet_t packet_i,
  output logic              free_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic              m_axis_tlast,
  output logic              m_axis_tuser
);

  logic [scpf_pkg::PKT_BYTES-1:0][7:0] bytes_q;
  logic [scpf_pkg::LEN_W-1:0]          rem_q, rem_d;
  logic                                chk_q;
  logic                                xfer;
  logic                                last_byte;

  assign last_byte = (rem_q == scpf_pkg::LEN_W'(1));
  assign xfer      = m_axis_tvalid && m_axis_tready;
  assign free_o    = (rem_q == '0) || (xfer && last_byte);

  // Count down the bytes still owed, reload on a new packet
  always_comb begin
    rem_d = rem_q;
    if (xfer) begin
      rem_d = rem_q - scpf_pkg::LEN_W'(1);
    end
    if (load_i) begin
      rem_d = packet_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // Shift the next byte into the head position
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= packet_i.bytes;
      chk_q   <= packet_i.has_check;
    end else if (xfer) begin
      bytes_q <= {8'h00, bytes_q[scpf_pkg::PKT_BYTES-1:1]};
    end
  end

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = bytes_q[0];
  assign m_axis_tlast  = last_byte;
  assign m_axis_tuser  = last_byte && chk_q;

endmodule

### design/scpf_checker.sv
// ---------------------------------------------------------------------------
// Servo command packet framer checker
// Port-level checks on the transmit byte stream.
// ---------------------------------------------------------------------------
`include "servo_command_packet_framer_unit_assert.svh"

module scpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  logic m_xfer;

  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // A checksum byte always closes the run of its command
  `SCPF_ASSERT_IMP(a_check_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                   m_axis_tlast, "checksum byte without tlast")

  // Checksums are masked to seven bits
  `SCPF_ASSERT_IMP(a_check_7bit, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                   !m_axis_tdata[7], "checksum byte has bit 7 set")

  // Bytes of one run follow without gaps
  `SCPF_ASSERT_NXT(a_run_contiguous, clk_i, rst_ni, m_axis_tvalid && m_xfer && !m_axis_tlast,
                   m_axis_tvalid, "gap inside a run of bytes")

  // A stalled byte holds its value
  `SCPF_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                   "output changed while stalled")

  // Accept a command whenever no byte is pending on the output
  `SCPF_ASSERT_IMP(a_idle_ready, clk_i, rst_ni, !m_axis_tvalid,
                   s_axis_tready, "input stalled with output idle")

endmodule

bind servo_command_packet_framer_unit scpf_checker u_scpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/servo_command_packet_framer_unit_test.sv
// ---------------------------------------------------------------------------
// Servo command packet framer testbench
// Streams operation, set and sync move commands into the framer and checks
// every transmit byte, its checksum flag and its end-of-command flag against
// a cycle-free model of the framing rules kept alongside the stimulus.
// ---------------------------------------------------------------------------
module servo_command_packet_framer_unit_test;
  import scpf_pkg::*;

  // One expected transmit byte
  typedef struct {
    logic [7:0] tx_byte;
    logic       end_of_packet;
    logic       last_of_run;
  } tx_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Commands waiting for the driver, bytes waiting for the monitor
  item_t    pending_cmds [$];
  tx_beat_t tx_expected [$];

  // Framing state of the model
  logic [6:0] frame_xor = '0;
  logic [4:0] owed_positions = '0;

  // Idle rates in percent, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic cmd_xfer = 1'b0;
  int   mismatches = 0;
  int   commands_taken = 0;
  int   bytes_checked = 0;
  int   frames_closed = 0;
  int   frames_abandoned = 0;
  int   positions_dropped = 0;

  servo_command_packet_framer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Work out the bytes one accepted command sends and advance the frame state
  task automatic frame_command(input item_t cmd);
    logic [7:0] beat_byte [6];
    logic       beat_eop [6];
    logic [7:0] sum;
    logic [4:0] last_id;
    int         n;
    n = 0;
    case (cmd.opcode)
      OP_OPERATION, OP_SET: begin
        if (owed_positions != 0) frames_abandoned++;
        owed_positions = '0;
        frame_xor = '0;
        beat_byte[0] = FRAME_HEADER;
        beat_byte[1] = cmd.data_a;
        beat_byte[2] = cmd.data_b;
        sum = cmd.data_a ^ cmd.data_b;
        n = 3;
        if (cmd.opcode == OP_SET) begin
          beat_byte[3] = cmd.data_c;
          beat_byte[4] = cmd.data_d;
          sum = sum ^ cmd.data_c ^ cmd.data_d;
          n = 5;
        end
        for (int i = 0; i < n; i++) beat_eop[i] = 1'b0;
        beat_byte[n] = {1'b0, sum[6:0]};
        beat_eop[n] = 1'b1;
        n++;
      end
      OP_SYNC_HEADER: begin
        if (owed_positions != 0) frames_abandoned++;
        last_id = (cmd.last_servo > MAX_LAST_ID) ? MAX_LAST_ID : cmd.last_servo;
        frame_xor = '0;
        owed_positions = last_id + 5'd1;
        beat_byte[0] = FRAME_HEADER;
        beat_byte[1] = {cmd.speed, MODE_LOW_BITS};
        beat_byte[2] = {3'b000, owed_positions};
        for (int i = 0; i < 3; i++) beat_eop[i] = 1'b0;
        n = 3;
      end
      default: begin
        if (owed_positions == 0) begin
          positions_dropped++;
        end else begin
          beat_byte[0] = cmd.position;
          beat_eop[0] = 1'b0;
          n = 1;
          frame_xor = frame_xor ^ cmd.position[6:0];
          owed_positions = owed_positions - 5'd1;
          if (owed_positions == 0) begin
            beat_byte[1] = {1'b0, frame_xor};
            beat_eop[1] = 1'b1;
            n = 2;
            frame_xor = '0;
            frames_closed++;
          end
        end
      end
    endcase
    for (int i = 0; i < n; i++)
      tx_expected.push_back('{beat_byte[i], beat_eop[i], i == n - 1});
  endtask

  // Monitor: check output transfers, then predict for input transfers
  always @(posedge clk_i) begin : monitor
    tx_beat_t want;
    item_t    cmd;
    cmd_xfer = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_checked++;
        if (tx_expected.size() == 0) begin
          $error("unexpected transmit byte %0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = tx_expected.pop_front();
          if (m_axis_tdata !== want.tx_byte) begin
            $error("tx_byte: expected %0h, got %0h", want.tx_byte, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.end_of_packet) begin
            $error("end_of_packet: expected %0b, got %0b", want.end_of_packet, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_axis_tlast);
            mismatches++;
          end
        end
      end
      cmd_xfer = s_axis_tvalid && s_axis_tready;
      if (cmd_xfer) begin
        cmd.opcode     = opcode_e'(s_axis_tuser);
        cmd.data_a     = s_axis_tdata[7:0];
        cmd.data_b     = s_axis_tdata[15:8];
        cmd.data_c     = s_axis_tdata[23:16];
        cmd.data_d     = s_axis_tdata[31:24];
        cmd.last_servo = s_axis_tdata[36:32];
        cmd.speed      = s_axis_tdata[39:37];
        cmd.position   = s_axis_tdata[47:40];
        commands_taken++;
        frame_command(cmd);
      end
    end
  end

  // Driver: hold a command until its transfer, then maybe idle, then send the next
  always @(negedge clk_i) begin : driver
    item_t c;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !cmd_xfer)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.opcode;
        s_axis_tdata  <= {c.position, c.speed, c.last_servo,
                          c.data_d, c.data_c, c.data_b, c.data_a};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Command with every field random
  function automatic item_t make_cmd(input opcode_e op);
    item_t c;
    c.opcode     = op;
    c.data_a     = 8'($urandom);
    c.data_b     = 8'($urandom);
    c.data_c     = 8'($urandom);
    c.data_d     = 8'($urandom);
    c.last_servo = 5'($urandom);
    c.speed      = 3'($urandom);
    c.position   = 8'($urandom);
    return c;
  endfunction

  function automatic item_t op_cmd(input logic [7:0] a, input logic [7:0] b);
    item_t c;
    c = make_cmd(OP_OPERATION);
    c.data_a = a;
    c.data_b = b;
    return c;
  endfunction

  function automatic item_t set_cmd(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] cc, input logic [7:0] d);
    item_t c;
    c = op_cmd(a, b);
    c.opcode = OP_SET;
    c.data_c = cc;
    c.data_d = d;
    return c;
  endfunction

  function automatic item_t hdr_cmd(input logic [4:0] last_id, input logic [2:0] spd);
    item_t c;
    c = make_cmd(OP_SYNC_HEADER);
    c.last_servo = last_id;
    c.speed = spd;
    return c;
  endfunction

  function automatic item_t pos_cmd(input logic [7:0] p);
    item_t c;
    c = make_cmd(OP_SYNC_POSITION);
    c.position = p;
    return c;
  endfunction

  // Mostly well-formed sync moves, plus single commands, broken moves and noise
  task automatic queue_random_traffic(input int target);
    item_t       hdr;
    item_t       c;
    int          counted;
    int unsigned roll;
    int          count;
    int          npos;
    counted = 0;
    while (counted < target) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        hdr = make_cmd(OP_SYNC_HEADER);
        case ($urandom_range(19))
          0:       hdr.last_servo = 5'd31;
          1:       hdr.last_servo = MAX_LAST_ID;
          default: hdr.last_servo = 5'($urandom_range(5));
        endcase
        count = ((hdr.last_servo > MAX_LAST_ID) ? MAX_LAST_ID : hdr.last_servo) + 1;
        npos = ($urandom_range(9) == 0) ? $urandom_range(count - 1) : count;
        pending_cmds.push_back(hdr);
        for (int i = 0; i < npos; i++) pending_cmds.push_back(make_cmd(OP_SYNC_POSITION));
        counted += 1 + npos;
      end else if (roll < 80) begin
        pending_cmds.push_back(make_cmd(($urandom_range(1) == 0) ? OP_OPERATION : OP_SET));
        counted++;
      end else begin
        c = make_cmd(opcode_e'($urandom_range(3)));
        pending_cmds.push_back(c);
        if (c.opcode != OP_SYNC_POSITION) counted++;
      end
    end
  endtask

  // Hold the sender until every queued command is out and every byte has come
  task automatic drain_all();
    while (pending_cmds.size() != 0 || s_axis_tvalid || tx_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every opcode, clamping, drops and abandons
    send_idle_pct = 37;
    recv_idle_pct = 53;
    pending_cmds.push_back(op_cmd(8'h00, 8'h00));
    pending_cmds.push_back(op_cmd(8'hFF, 8'hFF));
    pending_cmds.push_back(op_cmd(8'h80, 8'h01));
    pending_cmds.push_back(set_cmd(8'hFF, 8'h00, 8'hFF, 8'h00));
    pending_cmds.push_back(set_cmd(8'hA5, 8'h5A, 8'h3C, 8'h43));
    pending_cmds.push_back(pos_cmd(8'h11));               // no frame open: drop
    pending_cmds.push_back(hdr_cmd(5'd0, 3'd7));
    pending_cmds.push_back(pos_cmd(8'hFF));               // closes a one-servo move
    pending_cmds.push_back(pos_cmd(8'h00));               // after close: drop
    pending_cmds.push_back(hdr_cmd(5'd31, 3'd0));         // last id clamps to 30
    pending_cmds.push_back(pos_cmd(8'h12));
    pending_cmds.push_back(op_cmd(8'h7F, 8'h80));         // abandons the move
    pending_cmds.push_back(pos_cmd(8'h34));               // drop
    pending_cmds.push_back(hdr_cmd(5'd2, 3'd5));
    pending_cmds.push_back(pos_cmd(8'h55));
    pending_cmds.push_back(hdr_cmd(5'd1, 3'd2));          // header restarts the move
    pending_cmds.push_back(pos_cmd(8'h80));
    pending_cmds.push_back(pos_cmd(8'h7F));
    pending_cmds.push_back(hdr_cmd(5'd3, 3'd4));
    pending_cmds.push_back(pos_cmd(8'hC3));
    pending_cmds.push_back(set_cmd(8'h01, 8'h02, 8'h04, 8'h08)); // abandons the move
    pending_cmds.push_back(hdr_cmd(MAX_LAST_ID, 3'd3));
    pending_cmds.push_back(op_cmd(8'h00, 8'hFF));
    drain_all();

    // Random traffic under three idle mixes
    queue_random_traffic(42);
    drain_all();
    send_idle_pct = 53;
    recv_idle_pct = 37;
    queue_random_traffic(42);
    drain_all();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(42);
    drain_all();

    $display("covered %0d commands, %0d bytes checked, %0d sync moves closed,",
             commands_taken, bytes_checked, frames_closed);
    $display("%0d sync moves abandoned and %0d stray positions dropped",
             frames_abandoned, positions_dropped);
    if (mismatches == 0 && tx_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
